// ===== hdl/fst_pkg.sv =====
// ---------------------------------------------------------------------------
// fst_pkg
// Shared types and constants of the FIFO-replacement translation buffer.
// ---------------------------------------------------------------------------
`default_nettype none

package fst_pkg;

  localparam int CNT_W = 32;

  typedef enum logic [0:0] {
    OP_LOOKUP = 1'b0,
    OP_ADD    = 1'b1
  } fst_op_t;

  typedef logic [CNT_W-1:0] fst_cnt_t;

endpackage

`default_nettype wire

// ===== hdl/fst_if.sv =====
// ---------------------------------------------------------------------------
// fst_req_if / fst_rsp_if
// Valid/ready channels for translation requests and their results.
// ---------------------------------------------------------------------------
`default_nettype none

interface fst_req_if import fst_pkg::*; #(
  parameter int PAGE_W  = 16,
  parameter int FRAME_W = 16
);
  logic               valid;
  logic               ready;
  fst_op_t            op;
  logic [PAGE_W-1:0]  page;
  logic [FRAME_W-1:0] frame;
  logic               read_only;

  modport source (output valid, op, page, frame, read_only, input ready);
  modport sink   (input valid, op, page, frame, read_only, output ready);
endinterface

interface fst_rsp_if import fst_pkg::*; #(
  parameter int FRAME_W = 16
);
  logic               valid;
  logic               ready;
  logic               hit;
  logic [FRAME_W-1:0] frame_out;
  logic               read_only_out;
  fst_cnt_t           hits_total;
  fst_cnt_t           misses_total;
  fst_cnt_t           changes_total;

  modport source (output valid, hit, frame_out, read_only_out, hits_total,
                  misses_total, changes_total, input ready);
  modport sink   (input valid, hit, frame_out, read_only_out, hits_total,
                  misses_total, changes_total, output ready);
endinterface

`default_nettype wire

// ===== hdl/fst_slots.sv =====
// ---------------------------------------------------------------------------
// fst_slots
// Shifting slot array with parallel page compare and newest-first select.
// ---------------------------------------------------------------------------
`default_nettype none

module fst_slots import fst_pkg::*; #(
  parameter int ENTRIES    = 16,
  parameter int PAGE_BITS  = 16,
  parameter int FRAME_BITS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic [PAGE_BITS-1:0]  lk_page,
  output logic                       lk_hit,
  output logic [FRAME_BITS-1:0]      lk_frame,
  output logic                       lk_read_only,
  input  wire logic                  ins_en,
  input  wire logic [PAGE_BITS-1:0]  ins_page,
  input  wire logic [FRAME_BITS-1:0] ins_frame,
  input  wire logic                  ins_read_only
);

  logic [ENTRIES-1:0]    valid_r;
  logic [PAGE_BITS-1:0]  page_r  [ENTRIES];
  logic [FRAME_BITS-1:0] frame_r [ENTRIES];
  logic [ENTRIES-1:0]    ro_r;

  logic [ENTRIES-1:0] match;
  logic [ENTRIES-1:0] first;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (ins_en) begin
      valid_r <= {valid_r[ENTRIES-2:0], 1'b1};
    end
  end

  // advance every slot toward the end, drop the oldest
  always_ff @(posedge clk) begin
    if (ins_en) begin
      for (int i = ENTRIES - 1; i > 0; i--) begin
        page_r[i]  <= page_r[i-1];
        frame_r[i] <= frame_r[i-1];
      end
      page_r[0]  <= ins_page;
      frame_r[0] <= ins_frame;
      ro_r       <= {ro_r[ENTRIES-2:0], ins_read_only};
    end
  end

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      match[i] = valid_r[i] && (page_r[i] == lk_page);
    end
  end

  // lowest index is the newest slot
  assign first = match & (~match + ENTRIES'(1));

  always_comb begin
    lk_frame     = '0;
    lk_read_only = 1'b0;
    for (int i = 0; i < ENTRIES; i++) begin
      lk_frame     = lk_frame | (frame_r[i] & {FRAME_BITS{first[i]}});
      lk_read_only = lk_read_only | (ro_r[i] & first[i]);
    end
  end

  assign lk_hit = |match;

endmodule

`default_nettype wire

// ===== hdl/fifo_shift_tlb.sv =====
// ---------------------------------------------------------------------------
// fifo_shift_tlb
// Fully associative translation buffer with FIFO replacement.
// ---------------------------------------------------------------------------
// Usage:
//   in_req carries one request per valid/ready handshake: op selects a
//   lookup or the add of a page-to-frame mapping. out_rsp returns exactly
//   one result per request, in order: hit, frame and read-only mark of the
//   newest matching slot (zero on miss or add), and the running hit, miss
//   and add counts after that request. Counts wrap at 2^32.
//   A request passes through the input register, then the result register,
//   before its result shows on out_rsp.
//   Throughput: one request per cycle while out_rsp is not held; the slot
//   compare and newest-first select sit between the two registers, and an
//   add shifts all slots in the same cycle that a lookup would read them.
//   Reset (synchronous, rst_n low): all slots invalid, counters zero, both
//   registers empty.
//   Stall: while out_rsp is held, the result holds, one more request waits
//   in the input register, and in_req.ready drops once both are full.
// ---------------------------------------------------------------------------
`default_nettype none

module fifo_shift_tlb import fst_pkg::*; #(
  parameter int ENTRIES    = 16,
  parameter int PAGE_BITS  = 16,
  parameter int FRAME_BITS = 16
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  fst_req_if.sink    in_req,
  fst_rsp_if.source  out_rsp
);

  logic                  s1_valid_r, s1_valid_nxt;
  fst_op_t               s1_op_r;
  logic [PAGE_BITS-1:0]  s1_page_r;
  logic [FRAME_BITS-1:0] s1_frame_r;
  logic                  s1_ro_r;

  logic                  out_valid_r, out_valid_nxt;
  logic                  out_hit_r;
  logic [FRAME_BITS-1:0] out_frame_r;
  logic                  out_ro_r;

  fst_cnt_t hit_cnt_r,  hit_cnt_nxt;
  fst_cnt_t miss_cnt_r, miss_cnt_nxt;
  fst_cnt_t chg_cnt_r,  chg_cnt_nxt;

  logic                  advance;
  logic                  in_fire;
  logic                  is_lookup;
  logic                  lk_hit;
  logic [FRAME_BITS-1:0] lk_frame;
  logic                  lk_read_only;

  assign advance      = s1_valid_r && (!out_valid_r || out_rsp.ready);
  assign in_req.ready = !s1_valid_r || advance;
  assign in_fire      = in_req.valid && in_req.ready;
  assign is_lookup    = (s1_op_r == OP_LOOKUP);

  fst_slots #(
    .ENTRIES    (ENTRIES),
    .PAGE_BITS  (PAGE_BITS),
    .FRAME_BITS (FRAME_BITS)
  ) u_slots (
    .clk           (clk),
    .rst_n         (rst_n),
    .lk_page       (s1_page_r),
    .lk_hit        (lk_hit),
    .lk_frame      (lk_frame),
    .lk_read_only  (lk_read_only),
    .ins_en        (advance && (s1_op_r == OP_ADD)),
    .ins_page      (s1_page_r),
    .ins_frame     (s1_frame_r),
    .ins_read_only (s1_ro_r)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_rsp.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    hit_cnt_nxt  = hit_cnt_r;
    miss_cnt_nxt = miss_cnt_r;
    chg_cnt_nxt  = chg_cnt_r;
    if (advance) begin
      if (!is_lookup) begin
        chg_cnt_nxt = chg_cnt_r + CNT_W'(1);
      end else if (lk_hit) begin
        hit_cnt_nxt = hit_cnt_r + CNT_W'(1);
      end else begin
        miss_cnt_nxt = miss_cnt_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      hit_cnt_r   <= '0;
      miss_cnt_r  <= '0;
      chg_cnt_r   <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      hit_cnt_r   <= hit_cnt_nxt;
      miss_cnt_r  <= miss_cnt_nxt;
      chg_cnt_r   <= chg_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_op_r    <= in_req.op;
      s1_page_r  <= in_req.page;
      s1_frame_r <= in_req.frame;
      s1_ro_r    <= in_req.read_only;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_hit_r   <= is_lookup && lk_hit;
      out_frame_r <= (is_lookup && lk_hit) ? lk_frame : '0;
      out_ro_r    <= is_lookup && lk_hit && lk_read_only;
    end
  end

  assign out_rsp.valid         = out_valid_r;
  assign out_rsp.hit           = out_hit_r;
  assign out_rsp.frame_out     = out_frame_r;
  assign out_rsp.read_only_out = out_ro_r;
  assign out_rsp.hits_total    = hit_cnt_r;
  assign out_rsp.misses_total  = miss_cnt_r;
  assign out_rsp.changes_total = chg_cnt_r;

endmodule

`default_nettype wire

// ===== hdl/fst_checker.sv =====
// ---------------------------------------------------------------------------
// fst_checker
// Port-level checks of the translation buffer, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

module fst_checker import fst_pkg::*; #(
  parameter int FRAME_BITS = 16
) (
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  out_valid,
  input wire logic                  out_ready,
  input wire logic                  out_hit,
  input wire logic [FRAME_BITS-1:0] out_frame,
  input wire logic                  out_ro,
  input wire fst_cnt_t              hits,
  input wire fst_cnt_t              misses,
  input wire fst_cnt_t              changes
);

  fst_cnt_t last_sum_r;
  fst_cnt_t cur_sum;
  logic     out_fire;

  assign out_fire = out_valid && out_ready;
  assign cur_sum  = hits + misses + changes;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_sum_r <= '0;
    end else if (out_fire) begin
      last_sum_r <= cur_sum;
    end
  end

  // each result steps the sum of the three counters by exactly one
  a_one_event: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire |-> (cur_sum == last_sum_r + CNT_W'(1)))
    else $error("result count step is not one");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_hit) |-> (out_frame == '0 && !out_ro))
    else $error("miss or add carries a frame");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_frame) && $stable(hits) && $stable(misses)))
    else $error("stalled result changed");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind fifo_shift_tlb fst_checker #(
  .FRAME_BITS (FRAME_BITS)
) u_fst_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_rsp.valid),
  .out_ready (out_rsp.ready),
  .out_hit   (out_rsp.hit),
  .out_frame (out_rsp.frame_out),
  .out_ro    (out_rsp.read_only_out),
  .hits      (out_rsp.hits_total),
  .misses    (out_rsp.misses_total),
  .changes   (out_rsp.changes_total)
);

`default_nettype wire
